### src/ptsch_pkg.sv
`default_nettype none
package ptsch_pkg;

    localparam int MAX_TASKS_DEF = 16;
    localparam int TIME_BITS_DEF = 32;
    localparam int FIELD_W       = 32;
    localparam int INDEX_W       = 4;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_READ = 5'b00010,
        S_EVAL = 5'b00100,
        S_PUSH = 5'b01000,
        S_LAST = 5'b10000
    } t_state;

    localparam logic KIND_ADD  = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    typedef struct packed {
        logic               valid;
        logic [INDEX_W-1:0] task_index;
        logic [FIELD_W-1:0] elapsed;
        logic               last;
    } t_push;

    typedef struct packed {
        logic busy;
        logic pend_valid;
    } t_stat;

endpackage
`default_nettype wire

### src/ptsch_if.sv
`default_nettype none
interface ptsch_in_if;
    import ptsch_pkg::*;
    logic               valid;
    logic               ready;
    logic               kind;
    logic [FIELD_W-1:0] period;
    logic [FIELD_W-1:0] now;
    modport source (output valid, kind, period, now, input ready);
    modport sink (input valid, kind, period, now, output ready);
endinterface

interface ptsch_out_if;
    import ptsch_pkg::*;
    logic               valid;
    logic               ready;
    logic [INDEX_W-1:0] task_index;
    logic [FIELD_W-1:0] elapsed;
    logic               last;
    modport source (output valid, task_index, elapsed, last, input ready);
    modport sink (input valid, task_index, elapsed, last, output ready);
endinterface
`default_nettype wire

### src/periodic_task_scheduler.sv
// Channel   Dir  Beat contents
// i_in      in   kind, period, now
// o_out     out  task_index, elapsed, last
//
// An add beat is written from the idle state; a tick visits the read and evaluate
// states per stored task, the push state per firing task and then the last state.
// One firing is held back so that the last flag can be set on the final one.
// Reset empties the table at once; the task memory itself is never cleared.
// A stalled output holds the scan; a new beat is taken only between ticks.
`default_nettype none
module periodic_task_scheduler
    import ptsch_pkg::*;
#(
    parameter int MAX_TASKS = MAX_TASKS_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    ptsch_in_if.sink    i_in,
    ptsch_out_if.source o_out
);

    localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int ENT_W = 2 * TIME_BITS;

    t_push              push;
    t_stat              stat;
    logic               free;
    logic               we, re;
    logic [IDX_W-1:0]   waddr, raddr;
    logic [ENT_W-1:0]   wdata, rdata;

    ptsch_scan #(
        .MAX_TASKS (MAX_TASKS),
        .TIME_BITS (TIME_BITS)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_free  (free),
        .o_push  (push),
        .o_stat  (stat),
        .o_we    (we),
        .o_waddr (waddr),
        .o_wdata (wdata),
        .o_re    (re),
        .o_raddr (raddr),
        .i_rdata (rdata)
    );

    ptsch_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_TASKS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    ptsch_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_free  (free),
        .o_out   (o_out)
    );

`ifndef SYNTHESIS
    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.valid |-> free)
        else $error("Result pushed while the output register is occupied.");

    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.ready |-> !stat.pend_valid && !stat.busy)
        else $error("Input ready while a firing is still held back.");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.valid && push.last |=> i_in.ready)
        else $error("Scan did not return to idle after the final firing.");

    a_rw_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        re |-> !we)
        else $error("Task memory read and written in the same cycle.");
`endif

endmodule
`default_nettype wire

### src/ptsch_ram.sv
`default_nettype none
module ptsch_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

### src/ptsch_outq.sv
`default_nettype none
module ptsch_outq
    import ptsch_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire t_push  i_push,
    output logic        o_free,
    ptsch_out_if.source o_out
);

    logic               r_valid;
    logic [INDEX_W-1:0] r_index;
    logic [FIELD_W-1:0] r_elapsed;
    logic               r_last;

    assign o_free           = !r_valid || o_out.ready;
    assign o_out.valid      = r_valid;
    assign o_out.task_index = r_index;
    assign o_out.elapsed    = r_elapsed;
    assign o_out.last       = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push.valid) begin
            r_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_index   <= i_push.task_index;
            r_elapsed <= i_push.elapsed;
            r_last    <= i_push.last;
        end
    end

endmodule
`default_nettype wire

### src/ptsch_scan.sv
`default_nettype none
module ptsch_scan
    import ptsch_pkg::*;
#(
    parameter int MAX_TASKS = MAX_TASKS_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF,
    localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1,
    localparam int CNT_W = $clog2(MAX_TASKS + 1),
    localparam int ENT_W = 2 * TIME_BITS
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    ptsch_in_if.sink               i_in,
    input  wire logic              i_free,
    output t_push                  o_push,
    output t_stat                  o_stat,
    output logic                   o_we,
    output logic       [IDX_W-1:0] o_waddr,
    output logic       [ENT_W-1:0] o_wdata,
    output logic                   o_re,
    output logic       [IDX_W-1:0] o_raddr,
    input  wire logic  [ENT_W-1:0] i_rdata
);

    t_state                 r_state, n_state;
    logic [CNT_W-1:0]       r_count, n_count;
    logic [MAX_TASKS-1:0]   r_has_run, n_has_run;
    logic [TIME_BITS-1:0]   r_last_time, n_last_time;
    logic                   r_started, n_started;
    logic [TIME_BITS-1:0]   r_now, n_now;
    logic                   r_roll, n_roll;
    logic [TIME_BITS-1:0]   r_elapsed, n_elapsed;
    logic [IDX_W-1:0]       r_i, n_i;
    logic [IDX_W-1:0]       r_cand, n_cand;
    logic                   r_pend_valid, n_pend_valid;
    logic [IDX_W-1:0]       r_pend_idx, n_pend_idx;

    logic [TIME_BITS-1:0]   now_t, period_t, eff_last, rd_period, rd_due;
    logic                   accept, full, at_end, fire, tick_roll;

    assign now_t     = TIME_BITS'(i_in.now);
    assign period_t  = TIME_BITS'(i_in.period);
    assign rd_period = i_rdata[ENT_W-1:TIME_BITS];
    assign rd_due    = i_rdata[TIME_BITS-1:0];
    assign eff_last  = r_started ? r_last_time : now_t;
    assign tick_roll = eff_last > now_t;
    assign accept    = i_in.valid && i_in.ready;
    assign full      = (r_count == CNT_W'(MAX_TASKS));
    assign at_end    = (r_i == IDX_W'(r_count - CNT_W'(1)));
    assign fire      = r_roll || !r_has_run[r_i] || (rd_due < r_now);

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_stat.busy       = (r_state != S_IDLE);
    assign o_stat.pend_valid = r_pend_valid;
    assign o_raddr           = r_i;

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_has_run    = r_has_run;
        n_last_time  = r_last_time;
        n_started    = r_started;
        n_now        = r_now;
        n_roll       = r_roll;
        n_elapsed    = r_elapsed;
        n_i          = r_i;
        n_cand       = r_cand;
        n_pend_valid = r_pend_valid;
        n_pend_idx   = r_pend_idx;
        o_we         = 1'b0;
        o_waddr      = r_i;
        o_wdata      = {rd_period, rd_period + r_now};
        o_re         = 1'b0;
        o_push.valid      = 1'b0;
        o_push.task_index = INDEX_W'(r_pend_idx);
        o_push.elapsed    = FIELD_W'(r_elapsed);
        o_push.last       = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (accept && i_in.kind == KIND_ADD) begin
                    if (!full) begin
                        o_we    = 1'b1;
                        o_waddr = IDX_W'(r_count);
                        o_wdata = {period_t, {TIME_BITS{1'b0}}};
                        n_has_run[IDX_W'(r_count)] = 1'b0;
                        n_count = r_count + CNT_W'(1);
                    end
                end else if (accept) begin
                    n_started   = 1'b1;
                    n_last_time = now_t;
                    n_now       = now_t;
                    n_roll      = tick_roll;
                    n_elapsed   = tick_roll ? now_t : now_t - eff_last;
                    if (r_count != '0) begin
                        n_i     = '0;
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                o_re    = 1'b1;
                n_state = S_EVAL;
            end
            S_EVAL: begin
                if (fire) begin
                    o_we           = 1'b1;
                    n_has_run[r_i] = 1'b1;
                    n_cand         = r_i;
                    n_state        = S_PUSH;
                end else begin
                    n_i     = r_i + IDX_W'(1);
                    n_state = at_end ? S_LAST : S_READ;
                end
            end
            S_PUSH: begin
                if (!r_pend_valid || i_free) begin
                    o_push.valid = r_pend_valid;
                    n_pend_valid = 1'b1;
                    n_pend_idx   = r_cand;
                    n_i          = r_i + IDX_W'(1);
                    n_state      = at_end ? S_LAST : S_READ;
                end
            end
            S_LAST: begin
                if (!r_pend_valid) begin
                    n_state = S_IDLE;
                end else if (i_free) begin
                    o_push.valid = 1'b1;
                    o_push.last  = 1'b1;
                    n_pend_valid = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_has_run    <= '0;
            r_last_time  <= '0;
            r_started    <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_has_run    <= n_has_run;
            r_last_time  <= n_last_time;
            r_started    <= n_started;
            r_pend_valid <= n_pend_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_now      <= n_now;
        r_roll     <= n_roll;
        r_elapsed  <= n_elapsed;
        r_i        <= n_i;
        r_cand     <= n_cand;
        r_pend_idx <= n_pend_idx;
    end

endmodule
`default_nettype wire

### test/tb_top.sv
`default_nettype none
module tb_top;
    import ptsch_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [INDEX_W-1:0] task_index;
        logic [FIELD_W-1:0] elapsed;
        logic               last;
    } t_firing;

    typedef struct {
        logic               kind;
        logic [FIELD_W-1:0] period;
        logic [FIELD_W-1:0] now;
        bit                 typed;
        int                 n_exp;
        logic [INDEX_W-1:0] exp_index;
        logic [FIELD_W-1:0] exp_elapsed;
    } t_beat_row;

    logic i_clk;
    logic i_rst_n;

    ptsch_in_if  in_if ();
    ptsch_out_if out_if ();

    periodic_task_scheduler dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Scheduler image kept alongside the block.
    logic [FIELD_W-1:0] sched_period [MAX_TASKS_DEF];
    logic [FIELD_W-1:0] sched_due    [MAX_TASKS_DEF];
    bit                 sched_ran    [MAX_TASKS_DEF];
    int unsigned        sched_count;
    logic [FIELD_W-1:0] sched_prev_now;
    bit                 sched_started;

    t_firing   tick_firings [$];
    t_firing   firing_q [$];
    t_beat_row plan [$];

    bit                 row_typed;
    int                 row_n_exp;
    logic [INDEX_W-1:0] row_exp_index;
    logic [FIELD_W-1:0] row_exp_elapsed;

    bit stim_done;
    int faults;
    int add_beats;
    int full_adds;
    int tick_beats;
    int rollovers;
    int firings_checked;

    function automatic void schedule_beat(input logic kind, input logic [FIELD_W-1:0] per,
                                          input logic [FIELD_W-1:0] t_now);
        logic               rollover;
        logic [FIELD_W-1:0] base;
        t_firing            f;
        tick_firings.delete();
        if (kind == KIND_ADD) begin
            add_beats++;
            if (sched_count < MAX_TASKS_DEF) begin
                sched_period[sched_count] = per;
                sched_due[sched_count]    = '0;
                sched_ran[sched_count]    = 1'b0;
                sched_count++;
            end else begin
                full_adds++;
            end
            return;
        end
        tick_beats++;
        if (!sched_started) begin
            sched_prev_now = t_now;
            sched_started  = 1'b1;
        end
        rollover = sched_prev_now > t_now;
        if (rollover) begin
            rollovers++;
        end
        base = rollover ? '0 : sched_prev_now;
        for (int i = 0; i < sched_count; i++) begin
            if (rollover || !sched_ran[i] || sched_due[i] < t_now) begin
                sched_due[i] = t_now + sched_period[i];
                sched_ran[i] = 1'b1;
                f.task_index = i[INDEX_W-1:0];
                f.elapsed    = t_now - base;
                f.last       = 1'b0;
                tick_firings.push_back(f);
            end
        end
        if (tick_firings.size() > 0) begin
            f = tick_firings[tick_firings.size() - 1];
            f.last = 1'b1;
            tick_firings[tick_firings.size() - 1] = f;
        end
        sched_prev_now = t_now;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
    end

    always @(posedge i_clk) begin : watch
        t_firing e;
        if (i_rst_n) begin
            if (out_if.valid && out_if.ready) begin
                if (firing_q.size() == 0) begin
                    faults++;
                    $display("%0t: unexpected beat index %0d elapsed %0h last %0b", $time,
                             out_if.task_index, out_if.elapsed, out_if.last);
                end else begin
                    e = firing_q.pop_front();
                    firings_checked++;
                    if (out_if.task_index !== e.task_index) begin
                        faults++;
                        $display("%0t: task_index expected %0d actual %0d", $time,
                                 e.task_index, out_if.task_index);
                    end
                    if (out_if.elapsed !== e.elapsed) begin
                        faults++;
                        $display("%0t: elapsed expected %0h actual %0h", $time,
                                 e.elapsed, out_if.elapsed);
                    end
                    if (out_if.last !== e.last) begin
                        faults++;
                        $display("%0t: last expected %0b actual %0b", $time,
                                 e.last, out_if.last);
                    end
                end
            end
            if (in_if.valid && in_if.ready) begin
                schedule_beat(in_if.kind, in_if.period, in_if.now);
                if (row_typed) begin
                    for (int k = 0; k < row_n_exp; k++) begin
                        e.task_index = row_exp_index;
                        e.elapsed    = row_exp_elapsed;
                        e.last       = (k == row_n_exp - 1);
                        firing_q.push_back(e);
                    end
                end else begin
                    foreach (tick_firings[k]) firing_q.push_back(tick_firings[k]);
                end
            end
        end
    end

    initial begin : source
        t_beat_row          row;
        int                 item_no;
        int                 gap;
        int                 pick;
        logic [FIELD_W-1:0] cur_t;
        int                 add_periods [12];

        in_if.valid  = 1'b0;
        in_if.kind   = KIND_ADD;
        in_if.period = '0;
        in_if.now    = '0;
        row_typed       = 1'b0;
        row_n_exp       = 0;
        row_exp_index   = '0;
        row_exp_elapsed = '0;
        add_periods     = '{1, 2, 3, 5, 7, 10, 16, 25, 40, 64, 100, 150};

        plan.push_back(t_beat_row'{KIND_TICK, 32'h0, 32'd100, 1'b1, 0, 4'd0, 32'd0});
        plan.push_back(t_beat_row'{KIND_ADD, 32'h0, 32'h0, 1'b0, 0, 4'd0, 32'd0});
        plan.push_back(t_beat_row'{KIND_TICK, 32'h0, 32'd100, 1'b1, 1, 4'd0, 32'd0});
        plan.push_back(t_beat_row'{KIND_TICK, 32'h0, 32'd100, 1'b1, 0, 4'd0, 32'd0});
        plan.push_back(t_beat_row'{KIND_TICK, 32'h0, 32'd101, 1'b1, 1, 4'd0, 32'd1});
        plan.push_back(t_beat_row'{KIND_ADD, 32'hFFFF_FFFF, 32'h0, 1'b0, 0, 4'd0, 32'd0});
        plan.push_back(t_beat_row'{KIND_TICK, 32'h0, 32'd200, 1'b0, 0, 4'd0, 32'd0});
        plan.push_back(t_beat_row'{KIND_TICK, 32'h0, 32'd50, 1'b0, 0, 4'd0, 32'd0});
        plan.push_back(t_beat_row'{KIND_TICK, 32'h0, 32'hFFFF_FFFF, 1'b0, 0, 4'd0, 32'd0});
        plan.push_back(t_beat_row'{KIND_TICK, 32'h0, 32'h0, 1'b0, 0, 4'd0, 32'd0});
        foreach (add_periods[k]) begin
            plan.push_back(t_beat_row'{KIND_ADD, 32'(add_periods[k]),
                32'h0, 1'b0, 0, 4'd0, 32'd0});
        end
        plan.push_back(t_beat_row'{KIND_ADD, 32'h8000_0000, 32'h0, 1'b0, 0, 4'd0, 32'd0});
        plan.push_back(t_beat_row'{KIND_ADD, 32'h7FFF_FFFF, 32'h0, 1'b0, 0, 4'd0, 32'd0});
        plan.push_back(t_beat_row'{KIND_ADD, 32'hA5A5_A5A5, 32'h0, 1'b0, 0, 4'd0, 32'd0});
        plan.push_back(t_beat_row'{KIND_TICK, 32'h0, 32'h0, 1'b0, 0, 4'd0, 32'd0});
        plan.push_back(t_beat_row'{KIND_TICK, 32'h0, 32'd3, 1'b0, 0, 4'd0, 32'd0});

        cur_t   = 32'd3;
        item_no = 0;
        wait (i_rst_n);
        @(negedge i_clk);
        while (item_no < 450) begin
            if (item_no < plan.size()) begin
                row = plan[item_no];
            end else begin
                row.typed       = 1'b0;
                row.n_exp       = 0;
                row.exp_index   = '0;
                row.exp_elapsed = '0;
                row.period      = $urandom;
                row.now         = $urandom;
                if ($urandom_range(0, 9) == 0) begin
                    row.kind = KIND_ADD;
                end else begin
                    row.kind = KIND_TICK;
                    pick = $urandom_range(0, 99);
                    if (pick < 80) begin
                        cur_t += $urandom_range(0, 120);
                    end else if (pick < 88) begin
                        cur_t += $urandom_range(0, 2000);
                    end else if (pick < 94) begin
                        cur_t = $urandom;
                    end else begin
                        cur_t -= $urandom_range(1, 50);
                    end
                    row.now = cur_t;
                end
            end
            if ((item_no / 40) % 4 == 1) begin
                gap = 0;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 50) begin
                    gap = 0;
                end else if (pick < 90) begin
                    gap = $urandom_range(1, 3);
                end else begin
                    gap = $urandom_range(10, 40);
                end
            end
            if (gap > 0) begin
                in_if.valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            in_if.valid     = 1'b1;
            in_if.kind      = row.kind;
            in_if.period    = row.period;
            in_if.now       = row.now;
            row_typed       = row.typed;
            row_n_exp       = row.n_exp;
            row_exp_index   = row.exp_index;
            row_exp_elapsed = row.exp_elapsed;
            @(posedge i_clk);
            while (!in_if.ready) @(posedge i_clk);
            @(negedge i_clk);
            item_no++;
        end
        in_if.valid = 1'b0;
        stim_done   = 1'b1;
    end

    initial begin : sink
        int  hold;
        int  pick;
        bit  level;
        bit  squeezed;

        out_if.ready = 1'b0;
        hold     = 0;
        level    = 1'b0;
        squeezed = 1'b0;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            // A single long hold-off, so that the block backs up into its input.
            if (!squeezed && firings_checked >= 300) begin
                squeezed     = 1'b1;
                out_if.ready = 1'b0;
                repeat (400) @(negedge i_clk);
                hold = 0;
            end
            if (hold == 0) begin
                pick = $urandom_range(0, 99);
                if (pick < 15) begin
                    level = 1'b1;
                    hold  = $urandom_range(30, 120);
                end else if (pick < 75) begin
                    level = 1'b1;
                    hold  = $urandom_range(1, 6);
                end else if (pick < 95) begin
                    level = 1'b0;
                    hold  = $urandom_range(1, 3);
                end else begin
                    level = 1'b0;
                    hold  = $urandom_range(15, 40);
                end
            end
            hold--;
            out_if.ready = level;
        end
    end

    initial begin : wrap_up
        wait (stim_done);
        while (firing_q.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        $display("Covered %0d add beats (%0d into a full table) and %0d ticks (%0d rollovers).",
                 add_beats, full_adds, tick_beats, rollovers);
        $display("Checked %0d task firings; %0d field errors seen.", firings_checked, faults);
        if (faults == 0 && firing_q.size() == 0) begin
            $display("periodic_task_scheduler: match");
        end else begin
            $display("periodic_task_scheduler: mismatch");
        end
        $finish;
    end

    initial begin : watchdog
        #20_000_000;
        $display("Run stopped by the time limit with %0d firings outstanding.", firing_q.size());
        $display("periodic_task_scheduler: mismatch");
        $finish;
    end

endmodule
`default_nettype wire
